FILE: hdl/grid_cell_upper_bound_table_assert.svh
// ---------------------------------------------------------------------------
// Grid cell upper-bound table assertion macros
// Concurrent check macros, clocked on i_clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef GRID_CELL_UPPER_BOUND_TABLE_ASSERT_SVH
`define GRID_CELL_UPPER_BOUND_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define GCUB_ASSERT_HOLDS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("grid cell table: property failed");
// Condition that must never be true outside reset.
`define GCUB_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("grid cell table: forbidden condition seen");
`else
`define GCUB_ASSERT_HOLDS(lbl, prop)
`define GCUB_ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: hdl/gcub_pkg.sv
// ---------------------------------------------------------------------------
// Grid cell upper-bound table package
// Item and result types, command codes and fixed widths.
// ---------------------------------------------------------------------------
package gcub_pkg;

    localparam int COORD_W = 10;
    localparam int REG_W   = 11;
    localparam int GW      = 12;
    localparam int APB_AW  = 5;
    localparam int DATA_W  = 32;

    localparam logic [2:0] CMD_ADD       = 3'd0;
    localparam logic [2:0] CMD_QUERY_BOX = 3'd1;
    localparam logic [2:0] CMD_QUERY_ALL = 3'd2;
    localparam logic [2:0] CMD_SCALE     = 3'd3;
    localparam logic [2:0] CMD_SHIFT     = 3'd4;

    // Register group selected by address bit 4.
    localparam logic REG_GRP_CELL = 1'b1;

    localparam logic [REG_W-1:0] DOM_RESET  = 11'd1;
    localparam logic [REG_W-1:0] CELL_RESET = 11'd2;

    // -99999.0 saturates to the most negative Q16.16 value.
    localparam logic [31:0] NO_RESULT = 32'h8000_0000;
    localparam logic [31:0] SAT_MAX   = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [2:0]         command;
        logic [COORD_W-1:0] low_0;
        logic [COORD_W-1:0] high_0;
        logic [COORD_W-1:0] low_1;
        logic [COORD_W-1:0] high_1;
        logic [COORD_W-1:0] low_2;
        logic [COORD_W-1:0] high_2;
        logic [COORD_W-1:0] low_3;
        logic [COORD_W-1:0] high_3;
        logic [3:0]         low_open_mask;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        logic signed [31:0] bound;
        logic               found;
        logic               error;
    } t_result;

    typedef struct packed {
        logic               empty;
        logic signed [31:0] bound;
    } t_cell;

endpackage

FILE: hdl/grid_cell_upper_bound_table.sv
// ---------------------------------------------------------------------------
// Grid cell upper-bound table
// Keeps one Q16.16 bound and one empty flag per cell of a uniform grid.
// ---------------------------------------------------------------------------
// Usage: an item on the input channel (valid/ready) carries a command, a box
// of up to four dimensions and a value. Every item gives exactly one result
// item (bound, found, error) on the output channel. Add raises the bound of
// every covered cell, the two queries return the largest bound of non-empty
// cells, and scale and shift rework every non-empty bound with saturation.
// Operation: after a register write the grid geometry is rebuilt once, on
// the next item, then cached. A box command maps the box through the shared
// divider, forms the start cell index, then visits each covered cell.
// Whole-grid commands visit every cell, with an extra write-back step for a
// scaled non-empty cell. Each visited cell takes one read and at most one
// write on the cell memory port.
// Reset: every cell is marked empty by a clearing pass over all MAX_CELLS cells;
// no item is accepted during it, register writes are taken as usual.
// Stalls: a finished result waits in the output register; the next item is
// accepted meanwhile, and its own result waits until that register frees.
// ---------------------------------------------------------------------------
`include "grid_cell_upper_bound_table_assert.svh"

module grid_cell_upper_bound_table
    import gcub_pkg::*;
#(
    parameter int DIMS       = 4,
    parameter int MAX_CELLS  = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_item             i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_result           o_out_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int AW     = $clog2(MAX_CELLS);
    localparam int TW     = $clog2(MAX_CELLS + 1);
    localparam int DIW    = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int PW     = TW + GW;
    localparam int CELL_W = $bits(t_cell);
    localparam logic [16:0] COORD_LIM  = 17'(1 << COORD_W);
    localparam logic [16:0] COORD_MASK = COORD_LIM - 17'd1;

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_GDIV  = 13'b0000000000100,
        S_GMUL  = 13'b0000000001000,
        S_PREP  = 13'b0000000010000,
        S_LDIV  = 13'b0000000100000,
        S_HDIV  = 13'b0000001000000,
        S_SMUL  = 13'b0000010000000,
        S_SADD  = 13'b0000100000000,
        S_RD    = 13'b0001000000000,
        S_DAT   = 13'b0010000000000,
        S_WR    = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    // Configuration registers.
    logic [REG_W-1:0] r_dom   [4];
    logic [REG_W-1:0] r_cellp [4];
    logic             cfg_wr;

    // Sequencer and walk state.
    t_state            r_state;
    logic [DIW-1:0]    r_d;
    logic              r_div_go;
    logic              r_lin;
    t_item             r_item;
    logic              r_geo_valid;
    logic              r_geo_err;
    logic [TW-1:0]     r_total;
    logic [TW-1:0]     r_total_cells;
    logic [PW-1:0]     r_prod;
    logic [TW-1:0]     r_weight [DIMS];
    logic [GW-1:0]     r_lo     [DIMS];
    logic [GW-1:0]     r_hi     [DIMS];
    logic [GW-1:0]     r_wi     [DIMS];
    logic [TW-1:0]     r_row    [DIMS];
    logic [TW-1:0]     r_ix;
    logic signed [63:0] r_mul64;
    logic [31:0]       r_best;
    logic              r_found;
    logic              r_err;
    t_result           r_out;
    logic              r_out_valid;

    // Effective geometry per dimension.
    logic [GW-1:0] dom_e [4];
    logic [GW-1:0] cel_e [4];
    logic [COORD_W-1:0] lo_f [4];
    logic [COORD_W-1:0] hi_f [4];
    logic [1:0]    sel_d;
    logic [GW-1:0] sel_dom;
    logic [GW-1:0] sel_cel;
    logic [GW-1:0] low_c;
    logic [GW-1:0] high_c;
    logic [GW-1:0] high_clip;

    // Divider hookup.
    logic          div_start;
    logic [GW-1:0] div_num;
    logic          div_done;
    logic [GW-1:0] div_quo;

    // Cell memory hookup.
    logic              ram_we;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;
    t_cell             rd_cell;

    // Walk advance.
    logic           adv_last;
    logic [DIW-1:0] adv_d;
    logic [TW-1:0]  adv_ix;
    logic           step;

    // Arithmetic on the current cell.
    logic signed [32:0] add_sum;
    logic [31:0]        shift_res;
    logic signed [63:0] scale_rnd;
    logic signed [63:0] scale_q;
    logic [31:0]        scale_res;
    logic               out_load;

    // -----------------------------------------------------------------------
    // Configuration port. Writes land in the access phase; reads are direct.
    // -----------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < 4; d++) begin
                r_dom[d]   <= DOM_RESET;
                r_cellp[d] <= CELL_RESET;
            end
        end else if (cfg_wr) begin
            if (paddr[4] == REG_GRP_CELL) begin
                r_cellp[paddr[3:2]] <= pwdata[REG_W-1:0];
            end else begin
                r_dom[paddr[3:2]] <= pwdata[REG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[4] == REG_GRP_CELL) ? DATA_W'(r_cellp[paddr[3:2]])
                                               : DATA_W'(r_dom[paddr[3:2]]);

    // -----------------------------------------------------------------------
    // Clamped domain and cell sizes, and the box coordinates of the item.
    // -----------------------------------------------------------------------
    always_comb begin
        for (int d = 0; d < 4; d++) begin
            dom_e[d] = GW'(r_dom[d]);
            if (r_dom[d] == '0) begin
                dom_e[d] = GW'(1);
            end else if ({6'b0, r_dom[d]} > COORD_LIM) begin
                dom_e[d] = GW'(COORD_LIM);
            end
            cel_e[d] = (r_cellp[d] < REG_W'(2)) ? GW'(2) : GW'(r_cellp[d]);
            if (cel_e[d] > dom_e[d]) begin
                cel_e[d] = dom_e[d];
            end
        end
    end

    assign lo_f[0] = r_item.low_0;
    assign lo_f[1] = r_item.low_1;
    assign lo_f[2] = r_item.low_2;
    assign lo_f[3] = r_item.low_3;
    assign hi_f[0] = r_item.high_0;
    assign hi_f[1] = r_item.high_1;
    assign hi_f[2] = r_item.high_2;
    assign hi_f[3] = r_item.high_3;

    assign sel_d     = 2'(r_d);
    assign sel_dom   = dom_e[sel_d];
    assign sel_cel   = cel_e[sel_d];
    assign low_c     = GW'(lo_f[sel_d]) & GW'(COORD_MASK);
    assign high_c    = GW'(hi_f[sel_d]) & GW'(COORD_MASK);
    assign high_clip = (high_c > sel_dom - GW'(1)) ? sel_dom - GW'(1) : high_c;

    // One divider serves the cell counts of the geometry and both box edges.
    assign div_start = ((r_state == S_GDIV) || (r_state == S_LDIV) ||
                        (r_state == S_HDIV)) && !r_div_go;
    assign div_num   = (r_state == S_GDIV) ? sel_dom + sel_cel - GW'(1) :
                       (r_state == S_LDIV) ? low_c + GW'(r_item.low_open_mask[sel_d]) :
                                             high_clip;

    gcub_div #(
        .W (GW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (sel_cel),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // -----------------------------------------------------------------------
    // Cell memory: the empty flag and the bound share one word.
    // -----------------------------------------------------------------------
    assign rd_cell = t_cell'(ram_rdata);

    // Saturating shift of the current bound.
    assign add_sum   = {rd_cell.bound[31], rd_cell.bound} +
                       {r_item.value[31], r_item.value};
    assign shift_res = (add_sum[32] == add_sum[31]) ? add_sum[31:0] :
                       (add_sum[32] ? NO_RESULT : SAT_MAX);

    // Q16.16 product rounded half up, then saturated.
    assign scale_rnd = r_mul64 + 64'sd32768;
    assign scale_q   = scale_rnd >>> 16;
    assign scale_res = (scale_q > 64'sd2147483647)  ? SAT_MAX :
                       (scale_q < -64'sd2147483648) ? NO_RESULT : scale_q[31:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = CELL_W'(0);
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, 32'b0};
            end
            S_DAT: begin
                if (r_item.command == CMD_ADD) begin
                    ram_we = 1'b1;
                    if (rd_cell.empty || ($signed(r_item.value) > $signed(rd_cell.bound))) begin
                        ram_wdata = {1'b0, r_item.value};
                    end else begin
                        ram_wdata = {1'b0, rd_cell.bound};
                    end
                end else if ((r_item.command == CMD_SHIFT) && !rd_cell.empty) begin
                    ram_we    = 1'b1;
                    ram_wdata = {1'b0, shift_res};
                end
            end
            S_WR: begin
                ram_we    = 1'b1;
                ram_wdata = {1'b0, scale_res};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    gcub_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAX_CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ix[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_ix[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // -----------------------------------------------------------------------
    // Walk advance. A box walk bumps the lowest dimension that can still
    // move and restarts the ones below it; r_row keeps, per dimension, the
    // cell index at which the lower dimensions sit at their low edge.
    // -----------------------------------------------------------------------
    always_comb begin
        adv_last = 1'b1;
        adv_d    = '0;
        if (r_lin) begin
            adv_last = (TW'(r_ix + TW'(1)) == r_total_cells);
        end else begin
            for (int d = DIMS - 1; d >= 0; d--) begin
                if (r_wi[d] < r_hi[d]) begin
                    adv_last = 1'b0;
                    adv_d    = DIW'(d);
                end
            end
        end
        adv_ix = r_lin ? TW'(r_ix + TW'(1)) : TW'(r_row[adv_d] + r_weight[adv_d]);
    end

    // A cell is finished after its data cycle, or after the write-back of a
    // scaled bound.
    assign step = ((r_state == S_DAT) &&
                   !((r_item.command == CMD_SCALE) && !rd_cell.empty)) ||
                  (r_state == S_WR);

    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // -----------------------------------------------------------------------
    // Sequencer.
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ix        <= '0;
            r_d         <= '0;
            r_div_go    <= 1'b0;
            r_lin       <= 1'b0;
            r_geo_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_ix <= r_ix + TW'(1);
                    if (r_ix == TW'(MAX_CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_item;
                        r_best  <= NO_RESULT;
                        r_found <= 1'b0;
                        r_err   <= 1'b0;
                        r_lin   <= 1'b0;
                        r_d     <= '0;
                        r_total <= TW'(1);
                        r_state <= r_geo_valid ? S_PREP : S_GDIV;
                    end
                end
                S_GDIV: begin
                    if (!r_div_go) begin
                        r_div_go <= 1'b1;
                    end else if (div_done) begin
                        r_div_go      <= 1'b0;
                        r_weight[r_d] <= r_total;
                        r_prod        <= PW'(r_total) * PW'(div_quo);
                        r_state       <= S_GMUL;
                    end
                end
                S_GMUL: begin
                    if (r_prod > PW'(MAX_CELLS)) begin
                        r_geo_err   <= 1'b1;
                        r_geo_valid <= 1'b1;
                        r_state     <= S_PREP;
                    end else begin
                        r_total <= TW'(r_prod);
                        if (r_d == DIW'(DIMS - 1)) begin
                            r_geo_err     <= 1'b0;
                            r_geo_valid   <= 1'b1;
                            r_total_cells <= TW'(r_prod);
                            r_state       <= S_PREP;
                        end else begin
                            r_d     <= r_d + DIW'(1);
                            r_state <= S_GDIV;
                        end
                    end
                end
                S_PREP: begin
                    r_d <= '0;
                    if (r_geo_err) begin
                        r_err   <= 1'b1;
                        r_state <= S_OUT;
                    end else if ((r_item.command == CMD_ADD) ||
                                 (r_item.command == CMD_QUERY_BOX)) begin
                        r_state <= S_LDIV;
                    end else if ((r_item.command == CMD_QUERY_ALL) ||
                                 (r_item.command == CMD_SCALE) ||
                                 (r_item.command == CMD_SHIFT)) begin
                        r_lin   <= 1'b1;
                        r_ix    <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_LDIV: begin
                    if (!r_div_go) begin
                        r_div_go <= 1'b1;
                    end else if (div_done) begin
                        r_div_go  <= 1'b0;
                        r_lo[r_d] <= div_quo;
                        r_state   <= S_HDIV;
                    end
                end
                S_HDIV: begin
                    if (!r_div_go) begin
                        r_div_go <= 1'b1;
                    end else if (div_done) begin
                        r_div_go  <= 1'b0;
                        r_hi[r_d] <= div_quo;
                        // An inverted box collapses onto its high cell.
                        if (r_lo[r_d] > div_quo) begin
                            r_lo[r_d] <= div_quo;
                            r_wi[r_d] <= div_quo;
                        end else begin
                            r_wi[r_d] <= r_lo[r_d];
                        end
                        if (r_d == DIW'(DIMS - 1)) begin
                            r_d     <= '0;
                            r_ix    <= '0;
                            r_state <= S_SMUL;
                        end else begin
                            r_d     <= r_d + DIW'(1);
                            r_state <= S_LDIV;
                        end
                    end
                end
                S_SMUL: begin
                    r_prod  <= PW'(r_wi[r_d]) * PW'(r_weight[r_d]);
                    r_state <= S_SADD;
                end
                S_SADD: begin
                    r_ix <= r_ix + TW'(r_prod);
                    if (r_d == DIW'(DIMS - 1)) begin
                        for (int e = 0; e < DIMS; e++) begin
                            r_row[e] <= r_ix + TW'(r_prod);
                        end
                        r_state <= S_RD;
                    end else begin
                        r_d     <= r_d + DIW'(1);
                        r_state <= S_SMUL;
                    end
                end
                S_RD: begin
                    r_state <= S_DAT;
                end
                S_DAT: begin
                    if (!rd_cell.empty) begin
                        if ((r_item.command == CMD_QUERY_BOX) ||
                            (r_item.command == CMD_QUERY_ALL)) begin
                            if (!r_found || ($signed(rd_cell.bound) > $signed(r_best))) begin
                                r_best  <= rd_cell.bound;
                                r_found <= 1'b1;
                            end
                        end else if (r_item.command == CMD_SCALE) begin
                            r_mul64 <= 64'(rd_cell.bound) * 64'(r_item.value);
                            r_state <= S_WR;
                        end
                    end
                end
                S_WR: begin
                    // The walk advance below moves on after the write-back.
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out.bound <= r_best;
                        r_out.found <= r_found;
                        r_out.error <= r_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Move to the next cell, or finish the item.
            if (step) begin
                if (adv_last) begin
                    r_state <= S_OUT;
                end else begin
                    r_state <= S_RD;
                    r_ix    <= adv_ix;
                    if (!r_lin) begin
                        for (int e = 0; e < DIMS; e++) begin
                            if (DIW'(e) < adv_d) begin
                                r_wi[e]  <= r_lo[e];
                                r_row[e] <= adv_ix;
                            end else if (DIW'(e) == adv_d) begin
                                r_wi[e]  <= r_wi[e] + GW'(1);
                                r_row[e] <= adv_ix;
                            end
                        end
                    end
                end
            end

            // A new geometry is rebuilt on the next item.
            if (cfg_wr) begin
                r_geo_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;

    // -----------------------------------------------------------------------
    // Checks.
    // -----------------------------------------------------------------------
    `GCUB_ASSERT_HOLDS(a_clear_marks_empty, (r_state == S_CLEAR) |-> (ram_we && ram_wdata[CELL_W-1]))
    `GCUB_ASSERT_HOLDS(a_walk_in_grid, (r_state == S_RD) |-> (r_ix < r_total_cells))
    `GCUB_ASSERT_NEVER(a_found_with_error, o_out_valid && o_out_result.found && o_out_result.error)
    `GCUB_ASSERT_NEVER(a_idle_divider_free, (r_state == S_IDLE) && r_div_go)

endmodule

FILE: hdl/gcub_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module gcub_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/gcub_div.sv
// ---------------------------------------------------------------------------
// Grid cell table divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module gcub_div #(
    parameter int W = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    rem_sh;
    logic [W:0]    rem_sub;

    // The divisor must stay stable for the whole division.
    assign rem_sh  = {r_rem, r_quo[W-1]};
    assign rem_sub = rem_sh - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];
            r_quo <= {r_quo[W-2:0], ~rem_sub[W]};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: sim/tb_grid_cell_upper_bound_table.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Grid cell upper-bound table testbench
// Drives box adds, box and whole-grid queries, scale and shift through the
// item channel under random gaps on both sides. A behavioral copy of the
// cell store predicts each result, and a scoreboard checks every field.
// ---------------------------------------------------------------------------
module tb_grid_cell_upper_bound_table;
    import gcub_pkg::*;

    localparam int NCELLS = 4096;
    localparam int NDIMS  = 4;

    // Register indexes, laid out at byte address 4*index.
    localparam int REG_DOM0  = 0;
    localparam int REG_CELL0 = 4;

    // The scoreboard holds the results still owed by the block, oldest first.
    class result_board;
        t_result owed[$];
        int      errors;

        function void report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void note_item(t_result r);
            owed.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            want = owed.pop_front();
            if (got.bound !== want.bound)
                report($sformatf("bound %h, expected %h", got.bound, want.bound));
            if (got.found !== want.found)
                report($sformatf("found %b, expected %b", got.found, want.found));
            if (got.error !== want.error)
                report($sformatf("error %b, expected %b", got.error, want.error));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_item       i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_result     o_out_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_AW-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic        pready;

    result_board board;

    // Shadow of the block: registers, bounds and empty flags.
    logic [REG_W-1:0]   dom_reg [NDIMS];
    logic [REG_W-1:0]   cell_reg[NDIMS];
    logic signed [31:0] shadow_bound[NCELLS];
    bit                 shadow_empty[NCELLS];

    // Derived geometry, rebuilt for each item.
    int unsigned dom_last[NDIMS];
    int unsigned csize[NDIMS];
    int unsigned cweight[NDIMS];
    longint unsigned grid_cells;

    // Long receiver hold-off, started by the stimulus, counted down here.
    int  hold_cycles;
    bit  out_random;

    grid_cell_upper_bound_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_result(o_out_result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Geometry: clamp the registers, count cells, and flag overflow.
    function automatic bit build_grid();
        longint unsigned total;
        int unsigned dom, c;
        total = 1;
        for (int d = 0; d < NDIMS; d++) begin
            dom = dom_reg[d];
            c   = cell_reg[d];
            if (dom < 1) dom = 1;
            if (dom > 1024) dom = 1024;
            if (c < 2) c = 2;
            if (c > dom) c = dom;
            dom_last[d] = dom - 1;
            csize[d]    = c;
            cweight[d]  = total;
            total = total * ((dom + c - 1) / c);
            if (total > NCELLS) return 1'b0;
        end
        grid_cells = total;
        return 1'b1;
    endfunction

    function automatic logic signed [31:0] clip32(longint x);
        if (x > 64'sd2147483647) return SAT_MAX;
        if (x < -64'sd2147483648) return NO_RESULT;
        return x[31:0];
    endfunction

    // Q16.16 product, rounded half toward plus infinity.
    function automatic logic signed [31:0] q16_product(logic signed [31:0] a,
                                                       logic signed [31:0] b);
        longint p, q;
        p = longint'(a) * longint'(b) + 32768;
        if (p >= 0) q = p / 65536;
        else q = -((-p + 65535) / 65536);
        return clip32(q);
    endfunction

    // Works out the result of one item and updates the shadow store.
    function automatic t_result predict_bound(t_item it);
        t_result r;
        int unsigned lo[NDIMS], hi[NDIMS], idx[NDIMS];
        int unsigned lc, hc, ix;
        bit more;
        logic [COORD_W-1:0] lows[NDIMS], highs[NDIMS];
        r.bound = NO_RESULT;
        r.found = 1'b0;
        r.error = 1'b0;
        if (!build_grid()) begin
            r.error = 1'b1;
            return r;
        end
        lows  = '{it.low_0, it.low_1, it.low_2, it.low_3};
        highs = '{it.high_0, it.high_1, it.high_2, it.high_3};
        case (it.command)
            CMD_ADD, CMD_QUERY_BOX: begin
                for (int d = 0; d < NDIMS; d++) begin
                    lc = lows[d] + it.low_open_mask[d];
                    hc = highs[d];
                    if (hc > dom_last[d]) hc = dom_last[d];
                    lo[d] = lc / csize[d];
                    hi[d] = hc / csize[d];
                    if (lo[d] > hi[d]) lo[d] = hi[d];
                    idx[d] = lo[d];
                end
                // Walk order does not matter for max, so walk upward.
                more = 1'b1;
                while (more) begin
                    ix = 0;
                    for (int d = 0; d < NDIMS; d++) ix += idx[d] * cweight[d];
                    ix = ix % NCELLS;
                    if (it.command == CMD_ADD) begin
                        if (shadow_empty[ix] || it.value > shadow_bound[ix])
                            shadow_bound[ix] = it.value;
                        shadow_empty[ix] = 1'b0;
                    end else if (!shadow_empty[ix] &&
                                 (!r.found || shadow_bound[ix] > r.bound)) begin
                        r.bound = shadow_bound[ix];
                        r.found = 1'b1;
                    end
                    more = 1'b0;
                    for (int d = 0; d < NDIMS && !more; d++) begin
                        if (idx[d] < hi[d]) begin
                            idx[d]++;
                            more = 1'b1;
                        end else begin
                            idx[d] = lo[d];
                        end
                    end
                end
            end
            CMD_QUERY_ALL: begin
                for (int i = 0; i < grid_cells; i++)
                    if (!shadow_empty[i] && (!r.found || shadow_bound[i] > r.bound)) begin
                        r.bound = shadow_bound[i];
                        r.found = 1'b1;
                    end
            end
            CMD_SCALE, CMD_SHIFT: begin
                for (int i = 0; i < grid_cells; i++) begin
                    if (shadow_empty[i]) continue;
                    if (it.command == CMD_SCALE)
                        shadow_bound[i] = q16_product(shadow_bound[i], it.value);
                    else
                        shadow_bound[i] = clip32(longint'(shadow_bound[i]) +
                                                 longint'(it.value));
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // One APB write: setup cycle, then the access cycle.
    task automatic write_reg(int index, logic [REG_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * index);
        pwdata  <= DATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (index < REG_CELL0) dom_reg[index] = val;
        else cell_reg[index - REG_CELL0] = val;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.owed.size() != 0) @(posedge i_clk);
        // Every item has a result, so nothing is left at work inside.
        repeat (4) @(negedge i_clk);
    endtask

    // Writes a whole geometry, once the block has drained.
    task automatic set_geometry(logic [REG_W-1:0] d0, d1, d2, d3, c0, c1, c2, c3);
        wait_drained();
        write_reg(REG_DOM0,      d0);
        write_reg(REG_DOM0 + 1,  d1);
        write_reg(REG_DOM0 + 2,  d2);
        write_reg(REG_DOM0 + 3,  d3);
        write_reg(REG_CELL0,     c0);
        write_reg(REG_CELL0 + 1, c1);
        write_reg(REG_CELL0 + 2, c2);
        write_reg(REG_CELL0 + 3, c3);
    endtask

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one item, holds it until accepted, and notes the expectation.
    task automatic send_item(t_item it);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_item(predict_bound(it));
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        if (out_random) repeat (gap_length()) @(negedge i_clk);
    endtask

    function automatic t_item make_item(logic [2:0] cmd, int unsigned lo, hi,
                                        logic [3:0] open, logic signed [31:0] v);
        t_item it;
        it.command = cmd;
        it.low_0 = COORD_W'(lo); it.low_1 = COORD_W'(lo);
        it.low_2 = COORD_W'(lo); it.low_3 = COORD_W'(lo);
        it.high_0 = COORD_W'(hi); it.high_1 = COORD_W'(hi);
        it.high_2 = COORD_W'(hi); it.high_3 = COORD_W'(hi);
        it.low_open_mask = open;
        it.value = v;
        return it;
    endfunction

    // Random box, mostly small so that the walk stays short.
    function automatic t_item random_item();
        t_item it;
        logic [127:0] raw;
        int roll;
        raw = {$urandom(), $urandom(), $urandom(), $urandom()};
        it = raw[$bits(t_item)-1:0];
        roll = $urandom_range(0, 99);
        if (roll < 45) it.command = CMD_ADD;
        else if (roll < 75) it.command = CMD_QUERY_BOX;
        else if (roll < 85) it.command = CMD_QUERY_ALL;
        else if (roll < 91) it.command = CMD_SCALE;
        else if (roll < 97) it.command = CMD_SHIFT;
        else it.command = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 3) != 0) begin
            it.low_0  = COORD_W'($urandom_range(0, 40));
            it.high_0 = it.low_0 + COORD_W'($urandom_range(0, 12));
            it.low_1  = COORD_W'($urandom_range(0, 40));
            it.high_1 = it.low_1 + COORD_W'($urandom_range(0, 12));
            it.low_2  = COORD_W'($urandom_range(0, 40));
            it.high_2 = it.low_2 + COORD_W'($urandom_range(0, 12));
            it.low_3  = COORD_W'($urandom_range(0, 40));
            it.high_3 = it.low_3 + COORD_W'($urandom_range(0, 12));
        end
        if (it.command == CMD_SCALE)
            it.value = $urandom_range(0, 3) == 0 ? 32'($urandom())
                                                 : 32'($urandom_range(32768, 98304));
        else if (it.command == CMD_SHIFT && $urandom_range(0, 3) != 0)
            it.value = $signed(32'($urandom_range(0, 262144))) - 131072;
        return it;
    endfunction

    // Receiver: random stalls, plus a long hold-off when asked.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_cycles--;
            end else if (out_random && $urandom_range(0, 99) < 30) begin
                i_out_ready <= 1'b0;
                repeat (gap_length()) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && i_out_ready) board.check_result(o_out_result);

    // Stimulus and the end of the run.
    initial begin
        board = new();
        hold_cycles = 0;
        out_random = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        for (int d = 0; d < NDIMS; d++) begin
            dom_reg[d] = DOM_RESET;
            cell_reg[d] = CELL_RESET;
        end
        for (int i = 0; i < NCELLS; i++) begin
            shadow_empty[i] = 1'b1;
            shadow_bound[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset geometry is a single cell: query before and after an add.
        send_item(make_item(CMD_QUERY_ALL, 0, 0, 4'h0, 32'sd0));
        send_item(make_item(CMD_ADD, 0, 1023, 4'hF, 32'sh0001_0000));
        send_item(make_item(CMD_QUERY_BOX, 1023, 0, 4'h0, 32'sd0));

        // Small grid of 8 x 4 x 3 x 2 cells.
        set_geometry(11'd16, 11'd8, 11'd6, 11'd4, 11'd2, 11'd2, 11'd2, 11'd2);
        send_item(make_item(CMD_QUERY_BOX, 0, 1023, 4'h0, 32'sd0));
        send_item(make_item(CMD_ADD, 0, 0, 4'h0, 32'sh7FFF_FFFF));
        send_item(make_item(CMD_ADD, 1, 3, 4'hF, 32'sh8000_0000));
        send_item(make_item(CMD_ADD, 5, 2, 4'h5, -32'sd65536));
        send_item(make_item(CMD_ADD, 2, 1023, 4'hA, 32'sh0003_8000));
        send_item(make_item(CMD_QUERY_BOX, 1, 1, 4'h0, 32'sd0));
        send_item(make_item(CMD_QUERY_BOX, 1, 1, 4'hF, 32'sd0));
        send_item(make_item(CMD_QUERY_ALL, 0, 0, 4'h0, 32'sd0));
        send_item(make_item(CMD_SCALE, 0, 0, 4'h0, 32'sh0002_0000));
        send_item(make_item(CMD_SCALE, 0, 0, 4'h0, -32'sd32768));
        send_item(make_item(CMD_SCALE, 0, 0, 4'h0, 32'sh8000_0000));
        send_item(make_item(CMD_SHIFT, 0, 0, 4'h0, 32'sh7FFF_FFFF));
        send_item(make_item(CMD_SHIFT, 0, 0, 4'h0, 32'sh8000_0000));
        send_item(make_item(CMD_QUERY_ALL, 0, 0, 4'h0, 32'sd0));
        send_item(make_item(3'd7, 0, 1023, 4'h0, 32'sd5));

        // Clamped registers give a grid of 512 x 1 x 1 x 1 cells, within the limit.
        set_geometry(11'd1024, 11'd1024, 11'd1, 11'd1, 11'd1, 11'd1024, 11'd0, 11'd2047);
        send_item(make_item(CMD_ADD, 0, 1023, 4'h0, 32'sd9));
        send_item(make_item(CMD_QUERY_ALL, 0, 0, 4'h0, 32'sd0));

        // Random phases over several geometries, with idling on both sides.
        out_random = 1'b1;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_geometry(11'd64, 11'd16, 11'd8, 11'd4, 11'd4, 11'd4, 11'd2, 11'd2);
                1: set_geometry(11'd1024, 11'd20, 11'd1, 11'd1, 11'd8, 11'd10, 11'd1, 11'd1);
                2: set_geometry(11'd2047, 11'd0, 11'd3, 11'd1, 11'd1024, 11'd0, 11'd1, 11'd1);
                3: set_geometry(11'd40, 11'd30, 11'd5, 11'd7, 11'd3, 11'd5, 11'd2, 11'd3);
                default: set_geometry(11'd16, 11'd16, 11'd16, 11'd16,
                                      11'd2, 11'd2, 11'd2, 11'd2);
            endcase
            for (int n = 0; n < 150; n++) begin
                // Once per phase the receiver stops for a long while.
                if (n == 20) hold_cycles = 400;
                send_item(random_item());
            end
        end

        // Let every outstanding result arrive, with a limit.
        fork
            wait_drained();
            repeat (200000) @(posedge i_clk);
        join_any
        disable fork;
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (board.owed.size() != 0)
                board.report($sformatf("%0d results never arrived", board.owed.size()));
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard limit: the clearing pass, long walks and the longest stalls all fit
    // well inside this.
    initial begin
        #500_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
